@@ rtl/shs_pkg.sv @@
// Package for the stepper half-step sequencer: widths, command codes, step table.
package shs_pkg;

    localparam int COUNT_BITS_DEFAULT  = 16;
    localparam int PERIOD_BITS_DEFAULT = 24;

    localparam int KIND_W   = 2;
    localparam int STEPS_W  = 16;
    localparam int PHASE_W  = 4;
    localparam int CFG_W    = 24;
    localparam int INDEX_W  = 3;
    localparam int ROWS     = 8;

    localparam logic [CFG_W-1:0] PERIOD_RESET = CFG_W'(2000);

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef logic [PHASE_W-1:0] phase_t;

    localparam phase_t HALF_STEP_ROWS [ROWS] = '{
        4'b0001, 4'b0011, 4'b0010, 4'b0110,
        4'b0100, 4'b1100, 4'b1000, 4'b1001
    };

    typedef struct packed {
        phase_t phases;
        logic   busy_res;
        logic   stopped;
        logic   move_done;
    } result_t;

endpackage

@@ rtl/shs_channels.sv @@
// Handshake channels of the stepper half-step sequencer: command, result, configuration.
interface shs_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [shs_pkg::KIND_W-1:0]          kind;
    logic signed [shs_pkg::STEPS_W-1:0]  move_steps;
    logic                                latch_stop;

    modport source (output valid, kind, move_steps, latch_stop, input ready);
    modport sink   (input valid, kind, move_steps, latch_stop, output ready);
endinterface

interface shs_res_if;
    logic                           valid;
    logic                           ready;
    logic [shs_pkg::PHASE_W-1:0]    phases;
    logic                           busy_res;
    logic                           stopped;
    logic                           move_done;

    modport source (output valid, phases, busy_res, stopped, move_done, input ready);
    modport sink   (input valid, phases, busy_res, stopped, move_done, output ready);
endinterface

interface shs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [shs_pkg::CFG_W-1:0]      data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/stepper_half_step_sequencer.sv @@
// Top level of the stepper half-step sequencer: command decode, move state and result register.
//
// Usage:
//   cmd carries one command per transfer: tick, move, stop or clear of the stop flag.
//   res returns exactly one result per command: coil phases, busy, stop flag and
//   a done marker on the command that ends or cancels a move.
//   cfg writes the step period (ticks waited after each step); write it while idle.
// Latency and throughput:
//   The state update and result for a command are computed in the transfer cycle
//   and held in the result register, visible on res the next cycle. One command
//   is taken every cycle while results are drained; the single result register sets that figure.
// Stall:
//   While res holds a result the receiver has not taken, cmd.ready is low; it is
//   high whenever the result register is empty or being drained in that cycle.
// Reset:
//   rst_n clears the move state, the stop flag and the coil drive, empties the
//   result register and loads the step period with 2000. cfg is always ready.
module stepper_half_step_sequencer #(
    parameter int COUNT_BITS  = shs_pkg::COUNT_BITS_DEFAULT,
    parameter int PERIOD_BITS = shs_pkg::PERIOD_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    shs_cmd_if.sink     cmd,
    shs_res_if.source   res,
    shs_cfg_if.sink     cfg
);

    localparam int MAG_BITS  = shs_pkg::STEPS_W + 1;
    localparam int WIDE_BITS = (COUNT_BITS > MAG_BITS) ? COUNT_BITS : MAG_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [PERIOD_BITS-1:0]          step_period_reg;
    logic [shs_pkg::INDEX_W-1:0]     index_reg, index_next;
    logic [COUNT_BITS-1:0]           steps_left_reg, steps_left_next;
    logic                            backward_reg, backward_next;
    logic [PERIOD_BITS-1:0]          wait_reg, wait_next;
    logic                            stop_flag_reg, stop_flag_next;
    shs_pkg::phase_t                 drive_reg, drive_next;
    logic                            running_reg, running_next;
    logic                            done;

    logic                            res_valid_reg;
    shs_pkg::result_t                result_reg;

    logic                            cmd_xfer;
    logic                            move_neg;
    logic [MAG_BITS-1:0]             mag;
    logic [WIDE_BITS-1:0]            mag_wide;
    logic [COUNT_BITS-1:0]           mag_count;
    logic [shs_pkg::INDEX_W-1:0]     step_index;
    shs_pkg::kind_t                  kind;

    assign cfg.ready = 1'b1;
    assign cmd.ready = !res_valid_reg || res.ready;
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign kind      = shs_pkg::kind_t'(cmd.kind);

    // Magnitude of the signed count, saturated to the counter range
    assign move_neg  = cmd.move_steps[shs_pkg::STEPS_W-1];
    assign mag       = move_neg ? (MAG_BITS'(1) << shs_pkg::STEPS_W)
                                  - {1'b0, cmd.move_steps}
                                : {1'b0, cmd.move_steps};
    assign mag_wide  = WIDE_BITS'(mag);
    assign mag_count = (mag_wide > WIDE_BITS'(COUNT_MAX)) ? COUNT_MAX
                                                          : COUNT_BITS'(mag_wide);

    // Next state per command kind; a step advances the index, then mirrors it for backward runs
    always_comb
    begin
        index_next      = index_reg;
        steps_left_next = steps_left_reg;
        backward_next   = backward_reg;
        wait_next       = wait_reg;
        stop_flag_next  = stop_flag_reg;
        drive_next      = drive_reg;
        running_next    = running_reg;
        done            = 1'b0;
        step_index      = index_reg + 1'b1;
        unique case (kind)
            shs_pkg::KIND_TICK:
            begin
                if (running_reg)
                begin
                    if (wait_reg != '0)
                    begin
                        wait_next = wait_reg - 1'b1;
                    end
                    else if (steps_left_reg != '0)
                    begin
                        index_next      = step_index;
                        drive_next      = backward_reg
                                          ? shs_pkg::HALF_STEP_ROWS[~step_index]
                                          : shs_pkg::HALF_STEP_ROWS[step_index];
                        steps_left_next = steps_left_reg - 1'b1;
                        wait_next       = step_period_reg;
                    end
                    else
                    begin
                        running_next = 1'b0;
                        done         = 1'b1;
                    end
                end
            end
            shs_pkg::KIND_MOVE:
            begin
                if (!running_reg && !stop_flag_reg && mag_count != '0)
                begin
                    backward_next   = move_neg;
                    steps_left_next = mag_count;
                    wait_next       = '0;
                    running_next    = 1'b1;
                end
            end
            shs_pkg::KIND_STOP:
            begin
                drive_next = '0;
                if (cmd.latch_stop)
                begin
                    stop_flag_next = 1'b1;
                    if (running_reg)
                    begin
                        running_next    = 1'b0;
                        steps_left_next = '0;
                        wait_next       = '0;
                        done            = 1'b1;
                    end
                end
            end
            shs_pkg::KIND_CLEAR:
            begin
                stop_flag_next = 1'b0;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_period_reg <= PERIOD_BITS'(shs_pkg::PERIOD_RESET);
        end
        else if (cfg.valid)
        begin
            step_period_reg <= PERIOD_BITS'(cfg.data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg      <= '0;
            steps_left_reg <= '0;
            backward_reg   <= 1'b0;
            wait_reg       <= '0;
            stop_flag_reg  <= 1'b0;
            drive_reg      <= '0;
            running_reg    <= 1'b0;
        end
        else if (cmd_xfer)
        begin
            index_reg      <= index_next;
            steps_left_reg <= steps_left_next;
            backward_reg   <= backward_next;
            wait_reg       <= wait_next;
            stop_flag_reg  <= stop_flag_next;
            drive_reg      <= drive_next;
            running_reg    <= running_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd_xfer)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            result_reg <= '{phases:    drive_next,
                            busy_res:  running_next,
                            stopped:   stop_flag_next,
                            move_done: done};
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.phases    = result_reg.phases;
    assign res.busy_res  = result_reg.busy_res;
    assign res.stopped   = result_reg.stopped;
    assign res.move_done = result_reg.move_done;

`ifndef SYNTH
    a_no_run_while_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        !(stop_flag_reg && running_reg))
        else $error("move running while stop flag set");

    a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (steps_left_reg == '0 && wait_reg == '0))
        else $error("counters not clear while idle");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && result_reg.move_done |-> !result_reg.busy_res)
        else $error("move done reported while busy");

    a_wait_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer && kind == shs_pkg::KIND_TICK && running_reg && wait_reg != '0
        |=> wait_reg == $past(wait_reg) - 1'b1)
        else $error("wait count did not decrement on tick");
`endif

endmodule
